>>> rtl/lrbf_pkg.sv
// ----------------------------------------------------------------------------
// lrbf_pkg: shared types and codes for the log ring space manager
// Result status codes, request modes and the sequencer state type.
// ----------------------------------------------------------------------------
package lrbf_pkg;

    // Result status codes.
    localparam logic [2:0] STATUS_RESERVED = 3'd0;
    localparam logic [2:0] STATUS_EMPTY    = 3'd1;
    localparam logic [2:0] STATUS_NO_SPACE = 3'd2;
    localparam logic [2:0] STATUS_SEGMENT  = 3'd3;
    localparam logic [2:0] STATUS_NOTHING  = 3'd4;

    // Request modes.
    localparam logic MODE_RESERVE = 1'b0;
    localparam logic MODE_FLUSH   = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESERVE,
        ST_FLUSH
    } state_t;

endpackage

>>> rtl/log_ring_reserve_and_block_flush_core.sv
// ----------------------------------------------------------------------------
// log_ring_reserve_and_block_flush_core: circular log space manager
// Reserves wrapped regions for messages and drains the log block by block.
// A request is captured in ST_IDLE and handled in ST_RESERVE or ST_FLUSH;
// each result beat is registered. A flush gives one segment per cycle from
// the shared segment step, at most BLOCK_COUNT + 1 segments in all; busy
// stays high until the final result.
// Reset: write and drain offsets clear to zero (empty log); results are never
// stalled, each is valid for the single cycle that strobe is high.
// ----------------------------------------------------------------------------
module log_ring_reserve_and_block_flush_core #(
    parameter int BUFFER_BYTES = 65536,
    parameter int BLOCK_COUNT  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [15:0] msg_length,
    output logic        strobe,
    output logic [2:0]  status,
    output logic [15:0] first_offset,
    output logic [15:0] last_offset,
    output logic        near_full,
    output logic        last
);
    import lrbf_pkg::*;

    // Widths derived from the buffer geometry.
    localparam int OW   = $clog2(BUFFER_BYTES);
    localparam int FW   = OW + 1;
    localparam int CW   = ((FW > 17) ? FW : 17) + 1;
    localparam int XW   = (OW > 16) ? OW : 16;
    localparam int IW   = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int NW   = $clog2(BLOCK_COUNT + 1);
    localparam int BS_RAW = BUFFER_BYTES / BLOCK_COUNT;
    localparam int BS   = (BS_RAW == 0) ? 1 : BS_RAW;
    localparam int FIRST_END = (BLOCK_COUNT == 1) ? BUFFER_BYTES - 1 : BS - 1;

    localparam logic [CW-1:0] BUF_C  = CW'(BUFFER_BYTES);
    localparam logic [FW-1:0] HALF_F = FW'(BUFFER_BYTES / 2);
    localparam logic [OW-1:0] TOP_O  = OW'(BUFFER_BYTES - 1);
    localparam logic [OW-1:0] BS_O   = OW'(BS);
    localparam logic [OW-1:0] FEND_O = OW'(FIRST_END);
    localparam logic [IW-1:0] LAST_BLK = IW'(BLOCK_COUNT - 1);
    localparam logic [NW-1:0] MAX_SEG  = NW'(BLOCK_COUNT);

    // Control and offset state.
    state_t          state_reg, state_next;
    logic [OW-1:0]   wr_reg, wr_next;
    logic [OW-1:0]   dr_reg, dr_next;
    logic [IW-1:0]   blk_reg, blk_next;
    logic [OW-1:0]   bend_reg, bend_next;
    logic [NW-1:0]   seg_reg, seg_next;
    logic            strobe_reg, strobe_next;

    // Captured request and result beat.
    logic [15:0]     len_reg, len_next;
    logic [2:0]      status_reg, status_next;
    logic [OW-1:0]   first_reg, first_next;
    logic [OW-1:0]   lastoff_reg, lastoff_next;
    logic            last_reg, last_next;

    // Free byte count of the current state.
    logic [FW-1:0]   free_now;
    logic [CW-1:0]   free_c;
    logic [CW-1:0]   sum_c;
    logic [CW-1:0]   wrap_c;
    logic [OW-1:0]   new_wr;
    logic [XW-1:0]   first_x;
    logic [XW-1:0]   lastoff_x;

    always_comb
    begin
        if (wr_reg == dr_reg)
            free_now = FW'(BUFFER_BYTES);
        else if (wr_reg > dr_reg)
            free_now = FW'(BUFFER_BYTES) - {1'b0, wr_reg} + {1'b0, dr_reg};
        else
            free_now = {1'b0, dr_reg} - {1'b0, wr_reg};
    end

    // Reserve arithmetic: advance write offset with wrap.
    always_comb
    begin
        free_c = CW'(free_now);
        sum_c  = CW'(wr_reg) + CW'(len_reg);
        wrap_c = (sum_c >= BUF_C) ? (sum_c - BUF_C) : sum_c;
        new_wr = wrap_c[OW-1:0];
    end

    // Sequencer: next state and result beat.
    always_comb
    begin
        state_next   = state_reg;
        wr_next      = wr_reg;
        dr_next      = dr_reg;
        blk_next     = blk_reg;
        bend_next    = bend_reg;
        seg_next     = seg_reg;
        len_next     = len_reg;
        strobe_next  = 1'b0;
        status_next  = status_reg;
        first_next   = first_reg;
        lastoff_next = lastoff_reg;
        last_next    = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    len_next = msg_length;
                    seg_next = '0;
                    state_next = (mode == MODE_FLUSH) ? ST_FLUSH : ST_RESERVE;
                end
            end

            ST_RESERVE:
            begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
                state_next  = ST_IDLE;
                if (len_reg == '0)
                begin
                    status_next  = STATUS_EMPTY;
                    first_next   = '0;
                    lastoff_next = '0;
                end
                else if (CW'(len_reg) > BUF_C || !(free_c > CW'(len_reg)))
                begin
                    status_next  = STATUS_NO_SPACE;
                    first_next   = '0;
                    lastoff_next = '0;
                end
                else
                begin
                    status_next  = STATUS_RESERVED;
                    first_next   = wr_reg;
                    lastoff_next = (new_wr == '0) ? TOP_O : new_wr - OW'(1);
                    wr_next      = new_wr;
                end
            end

            ST_FLUSH:
            begin
                strobe_next = 1'b1;
                if (dr_reg == wr_reg)
                begin
                    // Only reached on the first step: the log is empty.
                    status_next  = STATUS_NOTHING;
                    first_next   = '0;
                    lastoff_next = '0;
                    last_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    status_next = STATUS_SEGMENT;
                    first_next  = dr_reg;
                    if (wr_reg <= bend_reg && wr_reg > dr_reg)
                    begin
                        // Segment stops just before the write offset.
                        lastoff_next = wr_reg - OW'(1);
                        dr_next      = wr_reg;
                    end
                    else
                    begin
                        // Segment runs to the block end; move to the next block.
                        // The top of the ring wraps even when single-byte blocks
                        // run out before the last block index.
                        lastoff_next = bend_reg;
                        if (blk_reg == LAST_BLK || bend_reg == TOP_O)
                        begin
                            dr_next   = '0;
                            blk_next  = '0;
                            bend_next = FEND_O;
                        end
                        else
                        begin
                            dr_next   = bend_reg + OW'(1);
                            blk_next  = blk_reg + IW'(1);
                            bend_next = (blk_reg + IW'(1) == LAST_BLK) ?
                                        TOP_O : bend_reg + BS_O;
                        end
                    end
                    last_next = (dr_next == wr_reg) || (seg_reg == MAX_SEG);
                    seg_next  = seg_reg + NW'(1);
                    if (last_next)
                        state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wr_reg     <= '0;
            dr_reg     <= '0;
            blk_reg    <= '0;
            bend_reg   <= FEND_O;
            seg_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wr_reg     <= wr_next;
            dr_reg     <= dr_next;
            blk_reg    <= blk_next;
            bend_reg   <= bend_next;
            seg_reg    <= seg_next;
            strobe_reg <= strobe_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        len_reg     <= len_next;
        status_reg  <= status_next;
        first_reg   <= first_next;
        lastoff_reg <= lastoff_next;
        last_reg    <= last_next;
    end

    // Output beat; near_full reflects the state after this beat's update.
    assign first_x      = XW'(first_reg);
    assign lastoff_x    = XW'(lastoff_reg);
    assign busy         = (state_reg != ST_IDLE);
    assign strobe       = strobe_reg;
    assign status       = status_reg;
    assign first_offset = first_x[15:0];
    assign last_offset  = lastoff_x[15:0];
    assign near_full    = (free_now < HALF_F);
    assign last         = last_reg;

endmodule

>>> tb/log_ring_reserve_and_block_flush_core_tb.sv
// ----------------------------------------------------------------------------
// log_ring_reserve_and_block_flush_core_tb: self-checking bench for the log ring
// A driver issues reserve and flush requests from a queue, and a predictor
// tracks the write and drain offsets to work out every result beat. A monitor
// compares each strobed beat, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module log_ring_reserve_and_block_flush_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lrbf_pkg::*;

    localparam int RING_BYTES  = 65536;
    localparam int RING_BLOCKS = 8;
    localparam int RANDOM_REQS = 294;

    typedef struct {
        logic        mode;
        logic [15:0] len;
    } ring_request_t;

    typedef struct {
        logic [2:0]  status;
        logic [15:0] first_ofs;
        logic [15:0] last_ofs;
        logic        near_full;
        logic        is_last;
    } ring_result_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        start      = 1'b0;
    logic        mode       = 1'b0;
    logic [15:0] msg_length = '0;
    logic        busy;
    logic        strobe;
    logic [2:0]  status;
    logic [15:0] first_offset;
    logic [15:0] last_offset;
    logic        near_full;
    logic        last;

    ring_request_t pending_reqs[$];
    ring_result_t  awaited_beats[$];

    // Predicted ring state.
    int unsigned wr_ofs = 0;
    int unsigned dr_ofs = 0;

    int total_reqs   = 0;
    int issued_reqs  = 0;
    int error_count  = 0;
    int n_reserved   = 0;
    int n_rejected   = 0;
    int n_segments   = 0;
    int n_idle_flush = 0;
    int n_checked    = 0;

    log_ring_reserve_and_block_flush_core #(
        .BUFFER_BYTES (RING_BYTES),
        .BLOCK_COUNT  (RING_BLOCKS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .msg_length   (msg_length),
        .strobe       (strobe),
        .status       (status),
        .first_offset (first_offset),
        .last_offset  (last_offset),
        .near_full    (near_full),
        .last         (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Free bytes in the ring; equal offsets mean the ring is empty.
    function automatic int unsigned ring_free_bytes();
        if (wr_ofs == dr_ofs)
            return RING_BYTES;
        if (wr_ofs > dr_ofs)
            return RING_BYTES - wr_ofs + dr_ofs;
        return dr_ofs - wr_ofs;
    endfunction

    // Queue one predicted beat; near_full reflects the state after the update.
    task automatic push_beat(input logic [2:0] st, input int unsigned a,
                             input int unsigned b, input logic fin);
        ring_result_t r;
        r.status    = st;
        r.first_ofs = a[15:0];
        r.last_ofs  = b[15:0];
        r.near_full = (ring_free_bytes() < RING_BYTES / 2);
        r.is_last   = fin;
        awaited_beats.push_back(r);
    endtask

    // Work out the beats caused by one accepted request and advance the offsets.
    task automatic compute_ring_results(input logic req_mode, input logic [15:0] req_len);
        int unsigned len;
        int unsigned bsz;
        int unsigned idx;
        int unsigned bstart;
        int unsigned bend;
        int unsigned seg_first;
        int unsigned seg_last;
        int unsigned nxt_ofs;
        int unsigned nseg;
        len = req_len;
        bsz = RING_BYTES / RING_BLOCKS;
        if (bsz == 0)
            bsz = 1;
        if (req_mode == MODE_RESERVE)
        begin
            if (len == 0)
            begin
                push_beat(STATUS_EMPTY, 0, 0, 1'b1);
                n_rejected++;
            end
            else if (len > RING_BYTES || ring_free_bytes() <= len)
            begin
                push_beat(STATUS_NO_SPACE, 0, 0, 1'b1);
                n_rejected++;
            end
            else
            begin
                seg_first = wr_ofs;
                nxt_ofs   = wr_ofs + len;
                if (nxt_ofs >= RING_BYTES)
                    nxt_ofs -= RING_BYTES;
                seg_last = (nxt_ofs == 0) ? RING_BYTES - 1 : nxt_ofs - 1;
                wr_ofs   = nxt_ofs;
                push_beat(STATUS_RESERVED, seg_first, seg_last, 1'b1);
                n_reserved++;
            end
        end
        else if (dr_ofs == wr_ofs)
        begin
            push_beat(STATUS_NOTHING, 0, 0, 1'b1);
            n_idle_flush++;
        end
        else
        begin
            // Drain block by block; a segment stops early only at the write offset.
            nseg = 0;
            while (dr_ofs != wr_ofs && nseg < RING_BLOCKS + 1)
            begin
                idx = dr_ofs / bsz;
                if (idx > RING_BLOCKS - 1)
                    idx = RING_BLOCKS - 1;
                bstart = idx * bsz;
                bend   = (idx == RING_BLOCKS - 1) ? RING_BYTES - 1 : (idx + 1) * bsz - 1;
                if (bend > RING_BYTES - 1)
                    bend = RING_BYTES - 1;
                seg_first = dr_ofs;
                if (wr_ofs >= bstart && wr_ofs <= bend && wr_ofs > dr_ofs)
                begin
                    seg_last = wr_ofs - 1;
                    nxt_ofs  = wr_ofs;
                end
                else
                begin
                    seg_last = bend;
                    nxt_ofs  = (bend + 1 >= RING_BYTES) ? 0 : bend + 1;
                end
                dr_ofs = nxt_ofs;
                push_beat(STATUS_SEGMENT, seg_first, seg_last,
                          (dr_ofs == wr_ofs) || (nseg == RING_BLOCKS));
                n_segments++;
                nseg++;
            end
        end
    endtask

    task automatic flag_error(input string what, input int got, input int want);
        if (error_count < 30)
            $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic queue_request(input logic req_mode, input logic [15:0] req_len);
        ring_request_t q;
        q.mode = req_mode;
        q.len  = req_len;
        pending_reqs.push_back(q);
    endtask

    // Driver: one request beat per handshake, with random sender gaps by phase.
    always @(posedge clk or negedge rst_n)
    begin
        ring_request_t nxt;
        int            idle_pct;
        if (!rst_n)
        begin
            start      <= 1'b0;
            mode       <= 1'b0;
            msg_length <= '0;
        end
        else
        begin
            if (start && !busy)
                compute_ring_results(mode, msg_length);
            if (!start || !busy)
            begin
                if (issued_reqs < total_reqs / 3)
                    idle_pct = 24;
                else if (issued_reqs < (2 * total_reqs) / 3)
                    idle_pct = 48;
                else
                    idle_pct = 0;
                if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    nxt = pending_reqs.pop_front();
                    issued_reqs++;
                    start      <= 1'b1;
                    mode       <= nxt.mode;
                    msg_length <= nxt.len;
                end
                else
                begin
                    start      <= 1'b0;
                    mode       <= 1'($urandom_range(1));
                    msg_length <= 16'($urandom_range(65535));
                end
            end
        end
    end

    // Monitor: every strobed beat is checked against the oldest prediction.
    always @(posedge clk)
    begin
        ring_result_t want;
        if (rst_n && strobe)
        begin
            if (awaited_beats.size() == 0)
                flag_error("result beat with nothing predicted", status, 0);
            else
            begin
                want = awaited_beats.pop_front();
                n_checked++;
                if (status !== want.status)
                    flag_error("status", status, want.status);
                if (first_offset !== want.first_ofs)
                    flag_error("first_offset", first_offset, want.first_ofs);
                if (last_offset !== want.last_ofs)
                    flag_error("last_offset", last_offset, want.last_ofs);
                if (near_full !== want.near_full)
                    flag_error("near_full", near_full, want.near_full);
                if (last !== want.is_last)
                    flag_error("last", last, want.is_last);
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int          pick;
        logic [15:0] len;
        // Empty flush, empty message, then a small write drained in one segment.
        queue_request(MODE_FLUSH, 16'd0);
        queue_request(MODE_RESERVE, 16'd0);
        queue_request(MODE_RESERVE, 16'd100);
        queue_request(MODE_FLUSH, 16'hFFFF);
        // Largest message wraps the ring leaving one free byte; the next is refused.
        queue_request(MODE_RESERVE, 16'hFFFF);
        queue_request(MODE_RESERVE, 16'd1);
        // Full drain from mid-block all the way round: the longest flush.
        queue_request(MODE_FLUSH, 16'd0);
        // Leave the write offset at the start of the drain block, then flush.
        queue_request(MODE_RESERVE, 16'd8193);
        queue_request(MODE_FLUSH, 16'd0);
        queue_request(MODE_RESERVE, 16'd65436);
        queue_request(MODE_FLUSH, 16'd0);
        // A region that ends exactly at the top of the ring.
        queue_request(MODE_RESERVE, 16'd57344);
        queue_request(MODE_RESERVE, 16'hFFFF);
        queue_request(MODE_FLUSH, 16'd0);
        // Half the ring free, then one byte under half.
        queue_request(MODE_RESERVE, 16'd32768);
        queue_request(MODE_RESERVE, 16'd1);
        queue_request(MODE_FLUSH, 16'h5555);

        // Random mix, mostly reserves of spread sizes with interleaved flushes.
        repeat (RANDOM_REQS)
        begin
            pick = $urandom_range(99);
            if (pick < 28)
                queue_request(MODE_FLUSH, 16'($urandom_range(65535)));
            else if (pick < 32)
                queue_request(MODE_RESERVE, 16'd0);
            else
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                    len = 16'($urandom_range(1023, 1));
                else if (pick < 70)
                    len = 16'($urandom_range(16383, 1024));
                else if (pick < 90)
                    len = 16'($urandom_range(65535, 16384));
                else
                    len = 16'($urandom_range(65535));
                queue_request(MODE_RESERVE, len);
            end
        end
        total_reqs = pending_reqs.size();

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() != 0 || start || awaited_beats.size() != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);

        if (awaited_beats.size() != 0)
            flag_error("predicted beats never seen", awaited_beats.size(), 0);
        $display("Ran %0d requests: %0d reservations, %0d refused, %0d drain segments,",
                 total_reqs, n_reserved, n_rejected, n_segments);
        $display("%0d flushes of an empty ring, %0d result beats compared.",
                 n_idle_flush, n_checked);
        if (error_count == 0)
            $display("log_ring_reserve_and_block_flush_core_tb: clean");
        else
            $display("log_ring_reserve_and_block_flush_core_tb: errors");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2000000;
        $display("Timed out waiting for the block.");
        $display("log_ring_reserve_and_block_flush_core_tb: errors");
        $finish;
    end

endmodule

>>> sim.f
rtl/lrbf_pkg.sv
rtl/log_ring_reserve_and_block_flush_core.sv
tb/log_ring_reserve_and_block_flush_core_tb.sv
